// File: hw/rtl/quaternion_multiply_normalize_unit_assert.svh
// Assertion macros for the quaternion multiply and normalize unit.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_UNIT_ASSERT_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_UNIT_ASSERT_SVH

// The consequent must hold at the edge where the antecedent holds.
`define QMN_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qmn assertion failed");

// The consequent must hold at the edge after the antecedent holds.
`define QMN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qmn assertion failed");

`endif

// File: hw/rtl/qmn_pkg.sv
// Shared constants, types and helpers of the quaternion multiply and normalize unit.
package qmn_pkg;

	// Default configuration.
	localparam int FRAC_BITS_DEF  = 14;
	localparam int COMP_WIDTH_DEF = 16;

	// Normalized magnitudes lie in [2^29, 2^30).
	localparam int MAG_BITS    = 30;
	localparam int NORM_TOP    = 29;
	localparam int NSQ_BITS    = 62;
	localparam int ROOT_BITS   = 31;
	localparam int SQRT_STAGES = 31;

	// Pipeline depths of the lane and normalizer sections.
	localparam int LANE_STAGES = 2;
	localparam int NORM_STAGES = 6;

	// Sign pattern of the four terms of each product component (bit k pairs with p[k]).
	typedef logic [3:0] neg_mask_t;
	localparam neg_mask_t NEG_RX = 4'b0100;
	localparam neg_mask_t NEG_RY = 4'b0001;
	localparam neg_mask_t NEG_RZ = 4'b0010;
	localparam neg_mask_t NEG_RW = 4'b0111;

	// Per-word flags that ride alongside the datapath.
	typedef struct packed {
		logic       zero;
		logic [3:0] neg;
	} qmn_flags_t;

	// Right shift applied to each product so that four-term sums fit in 64 bits.
	function automatic int prod_guard(input int cw);
		return ((2 * cw - 2) > 60) ? (2 * cw - 62) : 0;
	endfunction

endpackage

// File: hw/rtl/qmn_lane.sv
// One product lane: four signed multiplies and a signed four-term sum.
module qmn_lane #(
	parameter int COMP_WIDTH = qmn_pkg::COMP_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic signed [COMP_WIDTH-1:0] a [4],
	input  logic signed [COMP_WIDTH-1:0] b [4],
	input  qmn_pkg::neg_mask_t          neg,
	output logic signed [2*COMP_WIDTH-qmn_pkg::prod_guard(COMP_WIDTH)+1:0] sum
);
	import qmn_pkg::*;

	localparam int G  = prod_guard(COMP_WIDTH);
	localparam int PW = 2 * COMP_WIDTH - G;
	localparam int SW = PW + 2;

	logic signed [2*COMP_WIDTH-1:0] full [4];
	logic signed [PW-1:0]           prod_s1 [4];
	logic signed [SW-1:0]           acc;

	// Exact products.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			full[k] = a[k] * b[k];
		end
	end

	// Register the products after the floor guard shift.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s1[k] <= PW'(full[k] >>> G);
		end
	end

	// Signed sum of the four terms.
	always_comb begin
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			if (neg[k]) begin
				acc = acc - SW'(prod_s1[k]);
			end else begin
				acc = acc + SW'(prod_s1[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		sum <= acc;
	end

endmodule

// File: hw/rtl/qmn_norm.sv
// Merging stage: sign fix, magnitude scaling into [2^29, 2^30) and sum of squares.
module qmn_norm #(
	parameter int SUM_WIDTH = 34
) (
	input  logic                       clk,
	input  logic signed [SUM_WIDTH-1:0] r [4],
	output logic [qmn_pkg::MAG_BITS-1:0] mag [4],
	output logic [qmn_pkg::NSQ_BITS-1:0] nsq,
	output qmn_pkg::qmn_flags_t          flags
);
	import qmn_pkg::*;

	localparam int SW = SUM_WIDTH;
	localparam int NG = (SW + 7) / 8;
	localparam int PB = $clog2(NG * 8);
	localparam int EW = SW + MAG_BITS;

	logic [SW-1:0]       mag_s1 [4];
	logic [3:0]          neg_s1;
	logic [SW-1:0]       mag_s2 [4];
	logic [3:0]          neg_s2;
	logic [NG-1:0]       nz_s2;
	logic [2:0]          pos_s2 [NG];
	logic [SW-1:0]       mag_s3 [4];
	qmn_flags_t          flags_s3;
	logic [PB-1:0]       p_s3;
	logic [MAG_BITS-1:0] mag_s4 [4];
	qmn_flags_t          flags_s4;
	logic [2*MAG_BITS-1:0] sq_s5 [4];
	logic [MAG_BITS-1:0] mag_s5 [4];
	qmn_flags_t          flags_s5;
	logic [NSQ_BITS-1:0] nsq_s6;
	logic [MAG_BITS-1:0] mag_s6 [4];
	qmn_flags_t          flags_s6;

	logic [SW-1:0]       absr [4];
	logic [3:0]          negr;
	logic                flip;
	logic [SW-1:0]       orw;
	logic [NG*8-1:0]     orp;
	logic [NG-1:0]       nz;
	logic [2:0]          pos [NG];
	logic [PB-1:0]       p;
	logic [7:0]          sh_r;
	logic [7:0]          sh_l;
	logic [EW-1:0]       ext [4];
	logic [EW-1:0]       shv [4];

	// Stage 1: magnitudes and signs after the scalar sign fix.
	always_comb begin
		flip = r[3][SW-1];
		for (int k = 0; k < 4; k++) begin
			absr[k] = r[k][SW-1] ? SW'(-r[k]) : SW'(r[k]);
			negr[k] = flip ? (!r[k][SW-1] && (r[k] != '0)) : r[k][SW-1];
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= absr;
		neg_s1 <= negr;
	end

	// Stage 2: leading-one position within each byte of the combined magnitude.
	always_comb begin
		orw = mag_s1[0] | mag_s1[1] | mag_s1[2] | mag_s1[3];
		orp = (NG * 8)'(orw);
		for (int g = 0; g < NG; g++) begin
			nz[g]  = |orp[g*8 +: 8];
			pos[g] = 3'd0;
			for (int j = 0; j < 8; j++) begin
				if (orp[g*8 + j]) begin
					pos[g] = 3'(j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
		nz_s2  <= nz;
		pos_s2 <= pos;
	end

	// Stage 3: highest nonzero byte selects the leading-one position.
	always_comb begin
		p = '0;
		for (int g = 0; g < NG; g++) begin
			if (nz_s2[g]) begin
				p = PB'(g * 8) | PB'(pos_s2[g]);
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s3         <= mag_s2;
		p_s3           <= p;
		flags_s3.zero  <= ~|nz_s2;
		flags_s3.neg   <= neg_s2;
	end

	// Stage 4: common shift that puts the leading one at bit 29.
	always_comb begin
		sh_r = 8'(p_s3) - 8'(NORM_TOP);
		sh_l = 8'(NORM_TOP) - 8'(p_s3);
		for (int k = 0; k < 4; k++) begin
			ext[k] = EW'(mag_s3[k]);
			if (8'(p_s3) >= 8'(NORM_TOP)) begin
				shv[k] = ext[k] >> sh_r;
			end else begin
				shv[k] = ext[k] << sh_l;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			mag_s4[k] <= shv[k][MAG_BITS-1:0];
		end
		flags_s4 <= flags_s3;
	end

	// Stage 5: squares.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			sq_s5[k] <= mag_s4[k] * mag_s4[k];
		end
		mag_s5   <= mag_s4;
		flags_s5 <= flags_s4;
	end

	// Stage 6: sum of squares.
	always_ff @(posedge clk) begin
		nsq_s6   <= NSQ_BITS'(sq_s5[0]) + NSQ_BITS'(sq_s5[1])
		          + NSQ_BITS'(sq_s5[2]) + NSQ_BITS'(sq_s5[3]);
		mag_s6   <= mag_s5;
		flags_s6 <= flags_s5;
	end

	assign nsq   = nsq_s6;
	assign mag   = mag_s6;
	assign flags = flags_s6;

endmodule

// File: hw/rtl/qmn_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
module qmn_isqrt (
	input  logic                          clk,
	input  logic [qmn_pkg::NSQ_BITS-1:0]  n,
	output logic [qmn_pkg::ROOT_BITS-1:0] root
);
	import qmn_pkg::*;

	localparam int RMW = ROOT_BITS + 3;

	logic [RMW-1:0]       rem_s  [SQRT_STAGES+1];
	logic [ROOT_BITS-1:0] root_s [SQRT_STAGES+1];
	logic [NSQ_BITS-1:0]  n_s    [SQRT_STAGES+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign n_s[0]    = n;

	// One root bit per stage, from the top pair of radicand bits down.
	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic [RMW-1:0] remx;
		logic [RMW-1:0] trial;

		always_comb begin
			remx  = {rem_s[k][RMW-3:0], n_s[k][2*(SQRT_STAGES-1-k)+1 -: 2]};
			trial = RMW'({root_s[k], 2'b01});
		end

		always_ff @(posedge clk) begin
			n_s[k+1] <= n_s[k];
			if (remx >= trial) begin
				rem_s[k+1]  <= remx - trial;
				root_s[k+1] <= {root_s[k][ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= remx;
				root_s[k+1] <= {root_s[k][ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	assign root = root_s[SQRT_STAGES];

endmodule

// File: hw/rtl/qmn_div.sv
// Pipelined rounding divider: (mag * 2^FRAC_BITS + root/2) / root, one quotient bit per stage.
module qmn_div #(
	parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic [qmn_pkg::MAG_BITS-1:0]  mag,
	input  logic [qmn_pkg::ROOT_BITS-1:0] root,
	output logic [FRAC_BITS:0]            quo
);
	import qmn_pkg::*;

	localparam int NW = MAG_BITS + FRAC_BITS + 1;
	localparam int QS = FRAC_BITS + 1;

	logic [NW-1:0]        num_s0;
	logic [ROOT_BITS-1:0] den_s0;

	logic [ROOT_BITS-1:0] rem_s [QS+1];
	logic [ROOT_BITS-1:0] den_s [QS+1];
	logic [FRAC_BITS:0]   low_s [QS+1];
	logic [FRAC_BITS:0]   q_s   [QS+1];

	// Rounded numerator.
	always_ff @(posedge clk) begin
		num_s0 <= NW'({mag, {FRAC_BITS{1'b0}}}) + NW'(root >> 1);
		den_s0 <= root;
	end

	// The top numerator bits are already below the divisor.
	assign rem_s[0] = ROOT_BITS'(num_s0[NW-1:FRAC_BITS+1]);
	assign den_s[0] = den_s0;
	assign low_s[0] = num_s0[FRAC_BITS:0];
	assign q_s[0]   = '0;

	// Restoring division steps.
	for (genvar i = 0; i < QS; i++) begin : g_step
		logic [ROOT_BITS:0] remx;
		logic [ROOT_BITS:0] dx;

		always_comb begin
			remx = {rem_s[i], low_s[i][FRAC_BITS-i]};
			dx   = {1'b0, den_s[i]};
		end

		always_ff @(posedge clk) begin
			den_s[i+1] <= den_s[i];
			low_s[i+1] <= low_s[i];
			if (remx >= dx) begin
				rem_s[i+1] <= ROOT_BITS'(remx - dx);
				q_s[i+1]   <= {q_s[i][FRAC_BITS-1:0], 1'b1};
			end else begin
				rem_s[i+1] <= ROOT_BITS'(remx);
				q_s[i+1]   <= {q_s[i][FRAC_BITS-1:0], 1'b0};
			end
		end
	end

	assign quo = q_s[QS];

endmodule

// File: hw/rtl/quaternion_multiply_normalize_unit.sv
// Top level of the normalized JPL quaternion product unit.
//
// Accepts one quaternion pair on every clock cycle (busy is always low) and
// delivers each normalized product as a one-cycle done strobe; the
// receiver must take it then. Four product lanes run in parallel, a merging
// stage fixes the sign and scales the magnitudes, a 31-stage square-root
// pipeline forms the norm, and four rounding dividers with FRAC_BITS + 2
// stages each produce the components. The latency is set by the lanes,
// the merger, the root and divider pipelines and the output register.
module quaternion_multiply_normalize_unit #(
	parameter int FRAC_BITS  = qmn_pkg::FRAC_BITS_DEF,
	parameter int COMP_WIDTH = qmn_pkg::COMP_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COMP_WIDTH-1:0] q_x,
	input  logic signed [COMP_WIDTH-1:0] q_y,
	input  logic signed [COMP_WIDTH-1:0] q_z,
	input  logic signed [COMP_WIDTH-1:0] q_w,
	input  logic signed [COMP_WIDTH-1:0] p_x,
	input  logic signed [COMP_WIDTH-1:0] p_y,
	input  logic signed [COMP_WIDTH-1:0] p_z,
	input  logic signed [COMP_WIDTH-1:0] p_w,
	output logic                         done,
	output logic signed [COMP_WIDTH-1:0] r_x,
	output logic signed [COMP_WIDTH-1:0] r_y,
	output logic signed [COMP_WIDTH-1:0] r_z,
	output logic [COMP_WIDTH-2:0]        r_w,
	output logic                         zero_norm
);
	import qmn_pkg::*;

	`include "quaternion_multiply_normalize_unit_assert.svh"

	localparam int SW  = 2 * COMP_WIDTH - prod_guard(COMP_WIDTH) + 2;
	localparam int DIV_STAGES = FRAC_BITS + 2;
	localparam int FD  = SQRT_STAGES + DIV_STAGES;
	localparam int VD  = LANE_STAGES + NORM_STAGES + SQRT_STAGES + DIV_STAGES;
	localparam int LAT = VD + 1;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic signed [COMP_WIDTH-1:0] pv [4];
	logic signed [COMP_WIDTH-1:0] ax [4];
	logic signed [COMP_WIDTH-1:0] ay [4];
	logic signed [COMP_WIDTH-1:0] az [4];
	logic signed [COMP_WIDTH-1:0] aw [4];
	logic signed [SW-1:0]         rsum [4];

	logic [MAG_BITS-1:0]  mag [4];
	logic [NSQ_BITS-1:0]  nsq;
	qmn_flags_t           flags;
	logic [ROOT_BITS-1:0] root;
	logic [FRAC_BITS:0]   quo [4];

	logic [MAG_BITS-1:0]  magd_q [SQRT_STAGES][4];
	qmn_flags_t           flgd_q [FD];
	logic                 vld_q  [VD];

	logic [FRAC_BITS:0]   vc [4];
	logic [63:0]          sv [4];

	assign busy = 1'b0;

	// Operand routing for the four product lanes.
	assign pv = '{p_x, p_y, p_z, p_w};
	assign ax = '{q_w, q_z, q_y, q_x};
	assign ay = '{q_z, q_w, q_x, q_y};
	assign az = '{q_y, q_x, q_w, q_z};
	assign aw = '{q_x, q_y, q_z, q_w};

	qmn_lane #(.COMP_WIDTH(COMP_WIDTH)) u_lane_x (
		.clk(clk), .a(ax), .b(pv), .neg(NEG_RX), .sum(rsum[0])
	);
	qmn_lane #(.COMP_WIDTH(COMP_WIDTH)) u_lane_y (
		.clk(clk), .a(ay), .b(pv), .neg(NEG_RY), .sum(rsum[1])
	);
	qmn_lane #(.COMP_WIDTH(COMP_WIDTH)) u_lane_z (
		.clk(clk), .a(az), .b(pv), .neg(NEG_RZ), .sum(rsum[2])
	);
	qmn_lane #(.COMP_WIDTH(COMP_WIDTH)) u_lane_w (
		.clk(clk), .a(aw), .b(pv), .neg(NEG_RW), .sum(rsum[3])
	);

	// Merge the lanes into scaled magnitudes and their sum of squares.
	qmn_norm #(.SUM_WIDTH(SW)) u_norm (
		.clk(clk), .r(rsum), .mag(mag), .nsq(nsq), .flags(flags)
	);

	qmn_isqrt u_isqrt (
		.clk(clk), .n(nsq), .root(root)
	);

	// Hold the magnitudes while the root is formed.
	always_ff @(posedge clk) begin
		magd_q[0] <= mag;
		for (int i = 1; i < SQRT_STAGES; i++) begin
			magd_q[i] <= magd_q[i-1];
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_div
		qmn_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk(clk), .mag(magd_q[SQRT_STAGES-1][k]), .root(root), .quo(quo[k])
		);
	end

	// Flags follow the word through the root and divider pipelines.
	always_ff @(posedge clk) begin
		flgd_q[0] <= flags;
		for (int i = 1; i < FD; i++) begin
			flgd_q[i] <= flgd_q[i-1];
		end
	end

	// Valid line for the whole pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VD; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= start;
			for (int i = 1; i < VD; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Cap at 1.0, apply the component sign, and force zero for a zero norm.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vc[k] = (quo[k] > ONE) ? ONE : quo[k];
			if (flgd_q[FD-1].zero) begin
				sv[k] = '0;
			end else if (flgd_q[FD-1].neg[k]) begin
				sv[k] = 64'(0) - 64'(vc[k]);
			end else begin
				sv[k] = 64'(vc[k]);
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		r_x <= sv[0][COMP_WIDTH-1:0];
		r_y <= sv[1][COMP_WIDTH-1:0];
		r_z <= sv[2][COMP_WIDTH-1:0];
		r_w <= sv[3][COMP_WIDTH-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done      <= 1'b0;
			zero_norm <= 1'b0;
		end else begin
			done      <= vld_q[VD-1];
			zero_norm <= vld_q[VD-1] & flgd_q[FD-1].zero;
		end
	end

	// A delivered word always stems from a start a fixed latency earlier.
	`QMN_ASSERT_IMPL(a_done_latency, done, $past(start, LAT))
	// A zero-norm word carries all-zero components.
	`QMN_ASSERT_IMPL(a_zero_out, done && zero_norm,
		(r_x == '0) && (r_y == '0) && (r_z == '0) && (r_w == '0))
	// The zero-norm flag only appears with a word.
	`QMN_ASSERT_IMPL(a_zero_strobe, zero_norm, done)

endmodule
